[design/assert_macros.svh]
// assertion helpers used by pixel_format_converter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk_sig, rstn_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error("assertion failed");

// antecedent implies consequent, both sampled on the clock
`define ASSERT_IMPLY(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk_sig, rstn_sig, prop)
`define ASSERT_IMPLY(label, clk_sig, rstn_sig, ante, cons)

`endif

`endif

[design/pfc_pkg.sv]
package pfc_pkg;

    // pixel format code
    typedef logic [2:0] fmt_t;

    localparam fmt_t FMT_Y1       = 3'd0;
    localparam fmt_t FMT_Y2       = 3'd1;
    localparam fmt_t FMT_Y4       = 3'd2;
    localparam fmt_t FMT_Y8       = 3'd3;
    localparam fmt_t FMT_RGB565   = 3'd4;
    localparam fmt_t FMT_RGB888   = 3'd5;
    localparam fmt_t FMT_ARGB8888 = 3'd6;
    localparam fmt_t FMT_RGBA8888 = 3'd7;

    // formats after reset
    localparam fmt_t SRC_FMT_RESET = FMT_Y8;
    localparam fmt_t DST_FMT_RESET = FMT_ARGB8888;

    // configuration register indexes
    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SOURCE_FORMAT = 1'd0;
    localparam cfg_idx_t CFG_TARGET_FORMAT = 1'd1;

    // pixel word
    localparam int PIXEL_W = 32;
    typedef logic [PIXEL_W-1:0] pixel_t;

    // divide by three: (sum * 683) >> 11 is exact for sums up to 765
    localparam int          DIV3_SHIFT = 11;
    localparam logic [10:0] DIV3_MUL   = 11'd683;

    // unpacked channels
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } argb_t;

endpackage

[design/pixel_format_converter.sv]
// channel   direction  signals                             handshake
// input     in         start, pixel_in                     start and not busy
// result    out        done, pixel_out                     done strobe, one cycle
// config    in         cfg_valid, cfg_index, cfg_data      cfg_valid and cfg_ready
//
// one pixel word is taken every cycle; busy stays low
// the result appears with done after the word is taken, passing first into the input register
// and then through unpack/pack into the result register
// reset sets source format to Y8 and target format to ARGB8888, and clears the strobes
// the receiver cannot stall, so nothing is held back

`include "assert_macros.svh"

module pixel_format_converter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pfc_pkg::pixel_t      pixel_in,
    output logic                 done,
    output pfc_pkg::pixel_t      pixel_out,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  pfc_pkg::cfg_idx_t    cfg_index,
    input  pfc_pkg::fmt_t        cfg_data
);
    import pfc_pkg::*;

    fmt_t   src_fmt_reg;
    fmt_t   dst_fmt_reg;
    pixel_t in_pixel_reg;
    logic   in_valid_reg;
    pixel_t pixel_out_reg;
    logic   done_reg;
    pixel_t conv_result;
    logic   in_accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fmt_reg <= SRC_FMT_RESET;
            dst_fmt_reg <= DST_FMT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SOURCE_FORMAT: src_fmt_reg <= cfg_data;
                CFG_TARGET_FORMAT: dst_fmt_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_accept;
            done_reg     <= in_valid_reg;
        end
    end

    // input word register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_pixel_reg <= pixel_in;
        end
    end

    // format conversion
    pfc_convert u_convert (
        .src_fmt (src_fmt_reg),
        .dst_fmt (dst_fmt_reg),
        .pixel   (in_pixel_reg),
        .result  (conv_result)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            pixel_out_reg <= conv_result;
        end
    end

    assign done      = done_reg;
    assign pixel_out = pixel_out_reg;

    // checks
    `ASSERT_IMPLY(a_accept_to_done, clk, rst_n, in_accept, ##2 done)
    `ASSERT_IMPLY(a_done_had_accept, clk, rst_n, done, $past(in_accept, 2))
    `ASSERT_IMPLY(a_y1_narrow, clk, rst_n, done && (dst_fmt_reg == FMT_Y1), pixel_out[31:1] == 31'd0)
    `ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)

endmodule

[design/pfc_convert.sv]
module pfc_convert (
    input  pfc_pkg::fmt_t   src_fmt,
    input  pfc_pkg::fmt_t   dst_fmt,
    input  pfc_pkg::pixel_t pixel,
    output pfc_pkg::pixel_t result
);
    import pfc_pkg::*;

    argb_t       px;
    logic [9:0]  sum;
    logic [20:0] prod;
    logic [7:0]  y;

    // unpack source word to 8-bit channels
    always_comb
    begin
        px.a = 8'hff;
        px.r = 8'h00;
        px.g = 8'h00;
        px.b = 8'h00;
        case (src_fmt)
            FMT_Y1:
            begin
                px.r = (|pixel) ? 8'hff : 8'h00;
                px.g = px.r;
                px.b = px.r;
            end
            FMT_Y2:
            begin
                px.r = {4{pixel[1:0]}};
                px.g = px.r;
                px.b = px.r;
            end
            FMT_Y4:
            begin
                px.r = {2{pixel[3:0]}};
                px.g = px.r;
                px.b = px.r;
            end
            FMT_Y8:
            begin
                px.r = pixel[7:0];
                px.g = pixel[7:0];
                px.b = pixel[7:0];
            end
            FMT_RGB565:
            begin
                px.r = {pixel[15:11], pixel[15:13]};
                px.g = {pixel[10:5], pixel[10:9]};
                px.b = {pixel[4:0], pixel[4:2]};
            end
            FMT_RGB888:
            begin
                px.r = pixel[23:16];
                px.g = pixel[15:8];
                px.b = pixel[7:0];
            end
            FMT_ARGB8888:
            begin
                px.a = pixel[31:24];
                px.r = pixel[23:16];
                px.g = pixel[15:8];
                px.b = pixel[7:0];
            end
            default:
            begin
                px.r = pixel[31:24];
                px.g = pixel[23:16];
                px.b = pixel[15:8];
                px.a = pixel[7:0];
            end
        endcase
    end

    // luma as truncated mean of the three channels
    assign sum  = {2'b00, px.r} + {2'b00, px.g} + {2'b00, px.b};
    assign prod = {11'd0, sum} * {10'd0, DIV3_MUL};
    assign y    = prod[DIV3_SHIFT +: 8];

    // pack into target format
    always_comb
    begin
        case (dst_fmt)
            FMT_Y1:       result = {31'd0, y[7]};
            FMT_Y2:       result = {30'd0, y[7:6]};
            FMT_Y4:       result = {28'd0, y[7:4]};
            FMT_Y8:       result = {24'd0, y};
            FMT_RGB565:   result = {16'd0, px.r[7:3], px.g[7:2], px.b[7:3]};
            FMT_RGB888:   result = {8'd0, px.r, px.g, px.b};
            FMT_ARGB8888: result = {px.a, px.r, px.g, px.b};
            default:      result = {px.r, px.g, px.b, px.a};
        endcase
    end

endmodule
